// File: rtl/heartbeat_watchdog_with_health_level_defines.svh
// Assertion macros used by the heartbeat watchdog core.
`ifndef HEARTBEAT_WATCHDOG_WITH_HEALTH_LEVEL_DEFINES_SVH
`define HEARTBEAT_WATCHDOG_WITH_HEALTH_LEVEL_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define HWL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define HWL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/hwl_pkg.sv
// Types and constants shared by the heartbeat watchdog modules.
package hwl_pkg;

  localparam logic       OP_BEAT  = 1'b0;
  localparam logic       OP_CHECK = 1'b1;

  localparam logic [1:0] EV_CRITICAL = 2'd0;
  localparam logic [1:0] EV_WARNING  = 2'd1;
  localparam logic [1:0] EV_STALE    = 2'd2;

  localparam logic [31:0] THRESHOLD_RESET = 32'd15000;

  typedef struct packed {
    logic        opcode;
    logic [31:0] sender_id;
    logic [15:0] health_count;
    logic [47:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] current_count;
    logic [15:0] peak_count;
    logic [47:0] age_ms;
  } out_item_t;

  // Outcome of evaluating one item against the watchdog state.
  typedef struct packed {
    logic      emit;
    out_item_t item;
  } core_res_t;

endpackage

// File: rtl/hwl_in_stage.sv
// Input register stage of the heartbeat watchdog.
module hwl_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  hwl_pkg::in_item_t in_data,
  input  logic              advance,
  output logic              held_valid,
  output hwl_pkg::in_item_t held_data
);
  import hwl_pkg::*;

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_data <= in_data;
    end
  end

endmodule

// File: rtl/hwl_core.sv
// Watchdog state and single-pass evaluation of one heartbeat or check.
module hwl_core #(
  parameter int TIME_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               fire,
  input  hwl_pkg::in_item_t  item,
  output hwl_pkg::core_res_t res
);
  import hwl_pkg::*;

  logic [TIME_BITS-1:0] last_beat_time;
  logic                 beat_seen;
  logic [31:0]          registered_sender;
  logic                 stale_latched;
  logic [15:0]          peak_health;
  logic                 drop_latched;
  logic [31:0]          threshold;

  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] age;
  logic                 is_beat;
  logic                 sender_ok;
  logic [15:0]          peak_next;
  logic                 stale_fire;
  logic                 crit_fire;
  logic                 warn_fire;
  logic                 drop_clear;

  always_comb begin
    now_t     = TIME_BITS'(item.now_ms);
    age       = (now_t > last_beat_time) ? (now_t - last_beat_time) : '0;
    is_beat   = (item.opcode == OP_BEAT);
    sender_ok = !beat_seen || (item.sender_id == registered_sender);
    peak_next = (item.health_count > peak_health) ? item.health_count : peak_health;

    stale_fire = !is_beat && beat_seen && !stale_latched &&
                 (age >= TIME_BITS'(threshold));
    crit_fire  = is_beat && sender_ok && (peak_next != 16'd0) &&
                 (item.health_count == 16'd0) && !drop_latched;
    warn_fire  = is_beat && sender_ok && (peak_next != 16'd0) && !drop_latched &&
                 (item.health_count != 16'd0) && (item.health_count < peak_next);
    drop_clear = is_beat && sender_ok && (peak_next != 16'd0) &&
                 (item.health_count >= peak_next);

    res = '0;
    priority if (stale_fire) begin
      res.emit            = 1'b1;
      res.item.event_kind = EV_STALE;
      res.item.age_ms     = 48'(age);
    end else if (crit_fire) begin
      res.emit            = 1'b1;
      res.item.event_kind = EV_CRITICAL;
    end else if (warn_fire) begin
      res.emit               = 1'b1;
      res.item.event_kind    = EV_WARNING;
      res.item.current_count = item.health_count;
      res.item.peak_count    = peak_next;
    end else begin
      res.emit = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_beat_time    <= '0;
      beat_seen         <= 1'b0;
      registered_sender <= '0;
      stale_latched     <= 1'b0;
      peak_health       <= '0;
      drop_latched      <= 1'b0;
      threshold         <= THRESHOLD_RESET;
    end else begin
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (fire) begin
        if (stale_fire) begin
          stale_latched <= 1'b1;
        end
        if (is_beat && sender_ok) begin
          // The first heartbeat registers its sender; later ones match it.
          registered_sender <= item.sender_id;
          last_beat_time    <= now_t;
          beat_seen         <= 1'b1;
          stale_latched     <= 1'b0;
          peak_health       <= peak_next;
          if (crit_fire || warn_fire) begin
            drop_latched <= 1'b1;
          end else if (drop_clear) begin
            drop_latched <= 1'b0;
          end
        end
      end
    end
  end

`include "heartbeat_watchdog_with_health_level_defines.svh"

  `HWL_ASSERT_NOW(a_stale_needs_beat, fire && res.emit && res.item.event_kind == EV_STALE, beat_seen && !stale_latched, "stale event without a live heartbeat episode")
  `HWL_ASSERT_NEXT(a_stale_latches, fire && stale_fire, stale_latched, "stale latch not set after a stale event")
  `HWL_ASSERT_NOW(a_warn_below_peak, res.emit && res.item.event_kind == EV_WARNING, res.item.current_count < res.item.peak_count && res.item.current_count != 16'd0, "warning with count outside the dropped range")
  `HWL_ASSERT_NEXT(a_peak_monotonic, !rst, peak_health >= $past(peak_health), "peak health count went down")

endmodule

// File: rtl/hwl_out_stage.sv
// Result register stage of the heartbeat watchdog.
module hwl_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  hwl_pkg::core_res_t res,
  output logic               can_take,
  output logic               out_valid,
  input  logic               out_ready,
  output hwl_pkg::out_item_t out_data
);
  import hwl_pkg::*;

  // The slot may be refilled in the same cycle that its result is taken.
  assign can_take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= res.emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.emit) begin
      out_data <= res.item;
    end
  end

endmodule

// File: rtl/heartbeat_watchdog_with_health_level.sv
// Top level of the heartbeat watchdog with health level tracking.
//
//   Channel | Signals                          | Carries
//   --------+----------------------------------+------------------------------
//   in      | in_valid, in_ready, in_data      | heartbeat or check transaction
//   out     | out_valid, out_ready, out_data   | critical, warning or stale event
//   cfg     | cfg_we, cfg_wdata                | stale threshold in ms
//
// One transaction is accepted per cycle unless the output stalls; the input register
// captures it at the accepting edge and the result register loads its event once free.
// Transactions that cause no event simply drain through the input register.
// Reset (synchronous, active high) clears all watchdog state and sets the
// threshold to 15000 ms. A stalled output holds the result and, once the
// input register is also full, deasserts in_ready.
module heartbeat_watchdog_with_health_level #(
  parameter int TIME_BITS = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hwl_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output hwl_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);
  import hwl_pkg::*;

  logic      held_valid;
  in_item_t  held_data;
  logic      can_take;
  logic      fire;
  core_res_t res;

  assign fire = held_valid && can_take;

  hwl_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (fire),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  hwl_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (held_data),
    .res       (res)
  );

  hwl_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .res       (res),
    .can_take  (can_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: verif/heartbeat_watchdog_with_health_level_test.sv
// Self-checking testbench for the heartbeat watchdog with health level tracking.
module heartbeat_watchdog_with_health_level_test;
  import hwl_pkg::*;

  localparam logic [31:0] OWNER_ID = 32'hC0DE_7A11;
  localparam int          ROWS     = 18;
  localparam int          SETTLE   = 6;

  // One directed transaction; pinned rows carry a hand-written outcome.
  typedef struct packed {
    in_item_t  item;
    logic      pinned;
    logic      fires;
    out_item_t ev;
  } beat_row_t;

  localparam out_item_t NO_EVENT = '0;

  localparam beat_row_t SCRIPT [ROWS] = '{
    // A check before any heartbeat is ignored.
    '{'{OP_CHECK, 32'd0, 16'd0, 48'd100000}, 1'b1, 1'b0, NO_EVENT},
    // The first heartbeat registers its sender; a zero peak raises nothing.
    '{'{OP_BEAT, OWNER_ID, 16'd0, 48'd0}, 1'b1, 1'b0, NO_EVENT},
    '{'{OP_BEAT, 32'd0, 16'd5, 48'd500}, 1'b1, 1'b0, NO_EVENT},
    '{'{OP_BEAT, OWNER_ID, 16'hFFFF, 48'd1000}, 1'b1, 1'b0, NO_EVENT},
    '{'{OP_BEAT, OWNER_ID, 16'hFFFE, 48'd2000}, 1'b1, 1'b1,
      '{EV_WARNING, 16'hFFFE, 16'hFFFF, 48'd0}},
    // A zero count while the drop latch is set stays silent.
    '{'{OP_BEAT, OWNER_ID, 16'd0, 48'd3000}, 1'b1, 1'b0, NO_EVENT},
    '{'{OP_BEAT, OWNER_ID, 16'hFFFF, 48'd4000}, 1'b1, 1'b0, NO_EVENT},
    '{'{OP_BEAT, OWNER_ID, 16'd0, 48'd5000}, 1'b1, 1'b1,
      '{EV_CRITICAL, 16'd0, 16'd0, 48'd0}},
    '{'{OP_CHECK, 32'd0, 16'd0, 48'd19999}, 1'b1, 1'b0, NO_EVENT},
    '{'{OP_CHECK, 32'd0, 16'd0, 48'd20000}, 1'b1, 1'b1,
      '{EV_STALE, 16'd0, 16'd0, 48'd15000}},
    '{'{OP_CHECK, 32'd0, 16'd0, 48'd90000}, 1'b1, 1'b0, NO_EVENT},
    '{'{OP_BEAT, OWNER_ID, 16'hFFFF, 48'hFFFF_FFFF_FFFF}, 1'b1, 1'b0, NO_EVENT},
    // The clock going back gives an age of zero.
    '{'{OP_CHECK, 32'd0, 16'd0, 48'd0}, 1'b1, 1'b0, NO_EVENT},
    '{'{OP_CHECK, 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF}, 1'b1, 1'b0, NO_EVENT},
    '{'{OP_BEAT, OWNER_ID, 16'd1, 48'd100}, 1'b0, 1'b0, NO_EVENT},
    '{'{OP_BEAT, 32'hFFFF_FFFF, 16'd7, 48'd200}, 1'b1, 1'b0, NO_EVENT},
    '{'{OP_CHECK, 32'd0, 16'd0, 48'd15100}, 1'b0, 1'b0, NO_EVENT},
    '{'{OP_BEAT, OWNER_ID, 16'h8000, 48'd16000}, 1'b0, 1'b0, NO_EVENT}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;

  // Side information travelling with each directed transaction.
  logic      row_pinned = 1'b0;
  logic      row_fires = 1'b0;
  out_item_t row_event = '0;

  int send_idle_pct = 16;
  int recv_idle_pct = 70;
  int fault_count = 0;

  // Watchdog state as the testbench sees it.
  logic [47:0] wd_last_ms;
  logic        wd_seen;
  logic [31:0] wd_owner;
  logic        wd_stale;
  logic [15:0] wd_peak;
  logic        wd_dropped;
  logic [31:0] wd_threshold;

  out_item_t pending_events[$];

  // Stimulus-side time keeping.
  logic [47:0] stim_clock = '0;
  logic [47:0] stim_last_beat = '0;
  logic [31:0] thr_now = THRESHOLD_RESET;

  heartbeat_watchdog_with_health_level dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic log_fault(input string what);
    fault_count++;
    if (fault_count <= 10) begin
      $display("%s", what);
    end
  endtask

  function automatic logic predict_event(input in_item_t it, output out_item_t ev);
    logic [47:0] age;
    ev = '0;
    if (it.opcode == OP_CHECK) begin
      if (!wd_seen || wd_stale) return 1'b0;
      age = (it.now_ms > wd_last_ms) ? it.now_ms - wd_last_ms : '0;
      if (age >= {16'd0, wd_threshold}) begin
        wd_stale = 1'b1;
        ev.event_kind = EV_STALE;
        ev.age_ms = age;
        return 1'b1;
      end
      return 1'b0;
    end
    if (!wd_seen) begin
      wd_owner = it.sender_id;
    end else if (it.sender_id != wd_owner) begin
      return 1'b0;
    end
    wd_last_ms = it.now_ms;
    wd_seen = 1'b1;
    wd_stale = 1'b0;
    if (it.health_count > wd_peak) wd_peak = it.health_count;
    if (wd_peak != 16'd0) begin
      if (it.health_count == 16'd0 && !wd_dropped) begin
        wd_dropped = 1'b1;
        ev.event_kind = EV_CRITICAL;
        return 1'b1;
      end else if (it.health_count < wd_peak && it.health_count != 16'd0 && !wd_dropped) begin
        wd_dropped = 1'b1;
        ev.event_kind = EV_WARNING;
        ev.current_count = it.health_count;
        ev.peak_count = wd_peak;
        return 1'b1;
      end else if (it.health_count >= wd_peak) begin
        wd_dropped = 1'b0;
      end
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : scoreboard
    out_item_t ev;
    out_item_t want;
    logic      fires;
    if (rst) begin
      wd_last_ms = '0;
      wd_seen = 1'b0;
      wd_owner = '0;
      wd_stale = 1'b0;
      wd_peak = '0;
      wd_dropped = 1'b0;
      wd_threshold = THRESHOLD_RESET;
      pending_events.delete();
    end else begin
      if (cfg_we) wd_threshold = cfg_wdata;
      if (in_valid && in_ready) begin
        fires = predict_event(in_data, ev);
        if (row_pinned) begin
          fires = row_fires;
          ev = row_event;
        end
        if (fires) pending_events.push_back(ev);
      end
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          log_fault($sformatf("unexpected event: kind %0d cur %0d peak %0d age %0d",
                              out_data.event_kind, out_data.current_count,
                              out_data.peak_count, out_data.age_ms));
        end else begin
          want = pending_events.pop_front();
          if (out_data.event_kind !== want.event_kind ||
              out_data.current_count !== want.current_count ||
              out_data.peak_count !== want.peak_count ||
              out_data.age_ms !== want.age_ms) begin
            log_fault($sformatf({"event mismatch: expected kind %0d cur %0d peak %0d age %0d,",
                                 " got kind %0d cur %0d peak %0d age %0d"},
                                want.event_kind, want.current_count, want.peak_count,
                                want.age_ms, out_data.event_kind, out_data.current_count,
                                out_data.peak_count, out_data.age_ms));
          end
        end
      end
    end
  end

  // Presents one transaction and returns at the edge that accepts it.
  task automatic send_item(input in_item_t item, input logic pinned, input logic fires,
                           input out_item_t ev);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= item;
    row_pinned <= pinned;
    row_fires <= fires;
    row_event <= ev;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Holds the input back until every predicted event has been delivered.
  task automatic drain_events();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    thr_now = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly heartbeats from the registered sender with times placed around the threshold.
  task automatic run_random(input int count);
    in_item_t item;
    int       pick;
    for (int n = 0; n < count; n++) begin
      item.opcode = ($urandom_range(99) < 55) ? OP_BEAT : OP_CHECK;
      item.sender_id = ($urandom_range(99) < 85) ? OWNER_ID : 32'($urandom);
      pick = $urandom_range(99);
      item.health_count = (pick < 35) ? 16'hFFFF : (pick < 55) ? 16'd0 : 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 6) begin
        stim_clock = {16'($urandom), 32'($urandom)};
      end else if (pick < 12) begin
        stim_clock = stim_clock - 48'($urandom_range(0, 1000));
      end else if (pick < 24) begin
        stim_clock = stim_last_beat + 48'(thr_now) - 48'($urandom_range(0, 1));
      end else begin
        stim_clock = stim_clock + 48'(thr_now >> 1) * 48'($urandom_range(0, 3))
                     + 48'($urandom_range(0, 3));
      end
      item.now_ms = stim_clock;
      if (item.opcode == OP_BEAT && item.sender_id == OWNER_ID) stim_last_beat = stim_clock;
      send_item(item, 1'b0, 1'b0, NO_EVENT);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < ROWS; r++) begin
      send_item(SCRIPT[r].item, SCRIPT[r].pinned, SCRIPT[r].fires, SCRIPT[r].ev);
    end
    stim_clock = 48'd16000;
    stim_last_beat = 48'd16000;
    run_random(230);

    drain_events();
    write_threshold(32'd0);
    send_idle_pct = 70;
    recv_idle_pct = 16;
    run_random(230);

    drain_events();
    write_threshold(32'hFFFF_FFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(230);

    drain_events();
    write_threshold(32'($urandom_range(1, 5000)));
    run_random(230);

    in_valid <= 1'b0;
    for (int w = 0; w < 5000 && pending_events.size() != 0; w++) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (pending_events.size() != 0) begin
      log_fault($sformatf("%0d expected events never arrived", pending_events.size()));
    end
    if (fault_count == 0) begin
      $display("heartbeat_watchdog_with_health_level test passed");
    end else begin
      $display("heartbeat_watchdog_with_health_level test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("heartbeat_watchdog_with_health_level test failed");
    $finish;
  end

endmodule
